[sv/jhd_pkg.sv]
// ============================================================================
// JPEG Huffman bit decoder package
// Field widths, item kinds and result status codes shared by the decoder,
// its channel interfaces and its checker.
// ============================================================================
package jhd_pkg;

    // Payload field widths.
    localparam int KIND_W    = 3;
    localparam int TBL_REQ_W = 3;
    localparam int POS_W     = 8;
    localparam int BYTE_W    = 8;
    localparam int STATUS_W  = 3;
    localparam int CLEN_W    = 5;

    // Largest code count that one length can carry.
    localparam int COUNT_MAX = 'hFF;

    // Item kinds.
    localparam logic [KIND_W-1:0] K_BEGIN  = 3'd0;
    localparam logic [KIND_W-1:0] K_COUNT  = 3'd1;
    localparam logic [KIND_W-1:0] K_SYMBOL = 3'd2;
    localparam logic [KIND_W-1:0] K_FINISH = 3'd3;
    localparam logic [KIND_W-1:0] K_DECODE = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SYMBOL   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_STUCK    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNUSABLE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TOO_MANY = 3'd4;

endpackage

[sv/jhd_ifs.sv]
// ============================================================================
// JPEG Huffman bit decoder channels
// Valid/ready channels for the request beats and the result beats.
// ============================================================================
interface jhd_in_if;
    import jhd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [TBL_REQ_W-1:0] table_req;
    logic [POS_W-1:0]     position;
    logic [BYTE_W-1:0]    byte_value;
    logic                 bit_req;

    modport source (
        output valid, kind, table_req, position, byte_value, bit_req,
        input  ready
    );
    modport sink (
        input  valid, kind, table_req, position, byte_value, bit_req,
        output ready
    );
endinterface

interface jhd_out_if;
    import jhd_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   symbol;
    logic [CLEN_W-1:0]   code_length;

    modport source (
        output valid, status, symbol, code_length,
        input  ready
    );
    modport sink (
        input  valid, status, symbol, code_length,
        output ready
    );
endinterface

[sv/jpeg_huffman_bit_decoder.sv]
// ============================================================================
// JPEG Huffman bit decoder
// Loads canonical Huffman tables and decodes a compressed stream one bit per
// request beat, returning one result beat for every request beat.
// ============================================================================
//
//  Channel   Direction   Beat contents
//  --------  ----------  ---------------------------------------------------
//  i_in      sink        kind, table_req, position, byte_value, bit_req
//  o_out     source      status, symbol, code_length
//
//  Begin, count, symbol, rejected and unknown beats finish in the idle state. A
//  decode bit reads the count memory in S_LOOK, then the symbol memory in S_SYM
//  when a symbol is fetched. Finish sweeps the count memory, every length in turn.
//  Reset is synchronous; per-entry valid bits make counts read as zero, so no
//  clearing pass runs. A stalled result waits in a holding register, and no
//  request beat is taken until it moves on to the output register.
//
module jpeg_huffman_bit_decoder #(
    parameter int MAX_CODE_LENGTH = 16,
    parameter int TABLE_COUNT     = 8,
    parameter int MAX_SYMBOLS     = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jhd_in_if.sink    i_in,
    jhd_out_if.source o_out
);
    import jhd_pkg::*;

    localparam int TBL_W   = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
    localparam int LEN_AW  = (MAX_CODE_LENGTH > 1) ? $clog2(MAX_CODE_LENGTH) : 1;
    localparam int BITS_W  = $clog2(MAX_CODE_LENGTH + 1);
    localparam int PC_W    = MAX_CODE_LENGTH;
    localparam int FIRST_W = MAX_CODE_LENGTH + 1;
    localparam int OFF_W   = $clog2(MAX_SYMBOLS + 1);
    localparam int SYM_AW  = $clog2(MAX_SYMBOLS);
    localparam int CODE_W  = ((MAX_CODE_LENGTH > 8) ? MAX_CODE_LENGTH : 8) + 1;
    localparam int TOT_W   = $clog2(MAX_CODE_LENGTH * COUNT_MAX + MAX_SYMBOLS + 1);
    localparam int IDX_W   = OFF_W + 1;

    localparam logic [TBL_REQ_W:0] TBL_LIMIT   = (TBL_REQ_W + 1)'(TABLE_COUNT);
    localparam logic [POS_W:0]     LEN_LIMIT   = (POS_W + 1)'(MAX_CODE_LENGTH);
    localparam logic [POS_W:0]     SYM_LIMIT   = (POS_W + 1)'(MAX_SYMBOLS);
    localparam logic [LEN_AW-1:0]  LAST_LEN_IX = LEN_AW'(MAX_CODE_LENGTH - 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_FIN  = 5'b00010,
        S_LOOK = 5'b00100,
        S_SYM  = 5'b01000,
        S_PUSH = 5'b10000
    } t_state;

    typedef struct packed {
        logic [BYTE_W-1:0]  cnt;
        logic [FIRST_W-1:0] first;
        logic [OFF_W-1:0]   off;
    } t_len_ent;

    // Memories: per-length table data and the symbol lists.
    t_len_ent           r_len_mem [TABLE_COUNT][MAX_CODE_LENGTH];
    logic  [BYTE_W-1:0] r_sym_mem [TABLE_COUNT][MAX_SYMBOLS];
    t_len_ent           r_len_rd;
    logic  [BYTE_W-1:0] r_sym_rd;
    logic               r_rd_vld;

    // Per-table walk state.
    logic [TABLE_COUNT-1:0][MAX_CODE_LENGTH-1:0] r_cnt_vld;
    logic [TABLE_COUNT-1:0] r_usable;
    logic [TABLE_COUNT-1:0] r_stuck;
    logic [BITS_W-1:0]      r_longest [TABLE_COUNT];
    logic [PC_W-1:0]        r_partial [TABLE_COUNT];
    logic [BITS_W-1:0]      r_bits    [TABLE_COUNT];

    // Sequencer registers.
    t_state              r_state, n_state;
    logic [TBL_W-1:0]    r_tbl, n_tbl;
    logic [BITS_W-1:0]   r_len, n_len;
    logic [PC_W-1:0]     r_pc, n_pc;
    logic [LEN_AW-1:0]   r_fin_idx, n_fin_idx;
    logic [CODE_W-1:0]   r_code, n_code;
    logic [TOT_W-1:0]    r_total, n_total;
    logic [BITS_W-1:0]   r_fin_long, n_fin_long;
    logic                r_oversub, n_oversub;
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic [BYTE_W-1:0]   r_res_sym, n_res_sym;
    logic [CLEN_W-1:0]   r_res_clen, n_res_clen;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [BYTE_W-1:0]   r_out_sym;
    logic [CLEN_W-1:0]   r_out_clen;

    // Request decode.
    logic              acc, out_free, tbl_ok;
    logic [TBL_W-1:0]  acc_t;
    logic [BITS_W:0]   acc_len;

    // Memory controls.
    logic              len_re, len_we_cnt, len_we_fo, sym_re, sym_we;
    logic [TBL_W-1:0]  len_rt, len_wt;
    logic [LEN_AW-1:0] len_ra, len_wa;
    logic [SYM_AW-1:0] sym_ra;

    // Walk and table events.
    logic              ev_begin, ev_fin_start, ev_stuck, ev_walk, ev_fin_ok;
    logic [PC_W-1:0]   walk_pc;
    logic [BITS_W-1:0] walk_bits;

    // Result of the current beat.
    logic                done;
    logic [STATUS_W-1:0] done_status;
    logic [BYTE_W-1:0]   done_sym;
    logic [CLEN_W-1:0]   done_clen;

    // Lookup and finish datapath.
    logic [BYTE_W-1:0] rd_cnt;
    logic [CODE_W-1:0] lk_diff, fin_sum, fin_limit;
    logic              lk_match;
    logic [IDX_W-1:0]  lk_idx;
    logic [BITS_W-1:0] fin_len;
    logic [TOT_W-1:0]  fin_tot;
    logic              fin_ovs;

    assign acc      = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign tbl_ok   = {1'b0, i_in.table_req} < TBL_LIMIT;
    assign acc_t    = i_in.table_req[TBL_W-1:0];
    assign acc_len  = (BITS_W + 1)'(r_bits[acc_t]) + (BITS_W + 1)'(1);

    assign rd_cnt    = r_rd_vld ? r_len_rd.cnt : '0;
    assign lk_diff   = CODE_W'(r_pc) - CODE_W'(r_len_rd.first);
    assign lk_match  = (rd_cnt != '0) && (CODE_W'(r_pc) >= CODE_W'(r_len_rd.first))
                       && (lk_diff < CODE_W'(rd_cnt));
    assign lk_idx    = IDX_W'(r_len_rd.off) + IDX_W'(lk_diff[BYTE_W-1:0]);
    assign fin_len   = BITS_W'(r_fin_idx) + BITS_W'(1);
    assign fin_sum   = r_code + CODE_W'(rd_cnt);
    assign fin_limit = CODE_W'(1) << fin_len;
    assign fin_tot   = r_total + TOT_W'(rd_cnt);
    assign fin_ovs   = r_oversub || (fin_sum > fin_limit);

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_status;
    assign o_out.symbol      = r_out_sym;
    assign o_out.code_length = r_out_clen;

    always_comb begin
        n_state      = r_state;
        n_tbl        = r_tbl;
        n_len        = r_len;
        n_pc         = r_pc;
        n_fin_idx    = r_fin_idx;
        n_code       = r_code;
        n_total      = r_total;
        n_fin_long   = r_fin_long;
        n_oversub    = r_oversub;
        n_res_status = r_res_status;
        n_res_sym    = r_res_sym;
        n_res_clen   = r_res_clen;
        len_re       = 1'b0;
        len_rt       = acc_t;
        len_ra       = '0;
        len_we_cnt   = 1'b0;
        len_we_fo    = 1'b0;
        len_wt       = acc_t;
        len_wa       = i_in.position[LEN_AW-1:0];
        sym_re       = 1'b0;
        sym_we       = 1'b0;
        sym_ra       = lk_idx[SYM_AW-1:0];
        ev_begin     = 1'b0;
        ev_fin_start = 1'b0;
        ev_stuck     = 1'b0;
        ev_walk      = 1'b0;
        ev_fin_ok    = 1'b0;
        walk_pc      = '0;
        walk_bits    = '0;
        done         = 1'b0;
        done_status  = ST_OK;
        done_sym     = '0;
        done_clen    = '0;

        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_tbl = acc_t;
                    if (!tbl_ok) begin
                        done        = 1'b1;
                        done_status = ST_UNUSABLE;
                    end else begin
                        case (i_in.kind)
                            K_BEGIN: begin
                                ev_begin = 1'b1;
                                done     = 1'b1;
                            end
                            K_COUNT: begin
                                len_we_cnt = ({1'b0, i_in.position} < LEN_LIMIT);
                                done       = 1'b1;
                            end
                            K_SYMBOL: begin
                                sym_we = ({1'b0, i_in.position} < SYM_LIMIT);
                                done   = 1'b1;
                            end
                            K_FINISH: begin
                                ev_fin_start = 1'b1;
                                len_re       = 1'b1;
                                n_fin_idx    = '0;
                                n_code       = '0;
                                n_total      = '0;
                                n_fin_long   = '0;
                                n_oversub    = 1'b0;
                                n_state      = S_FIN;
                            end
                            K_DECODE: begin
                                if (!r_usable[acc_t]) begin
                                    done        = 1'b1;
                                    done_status = ST_UNUSABLE;
                                end else if (r_stuck[acc_t]) begin
                                    done        = 1'b1;
                                    done_status = ST_STUCK;
                                end else if (acc_len > (BITS_W + 1)'(r_longest[acc_t])) begin
                                    ev_stuck    = 1'b1;
                                    done        = 1'b1;
                                    done_status = ST_STUCK;
                                end else begin
                                    // The count entry for the next length is the
                                    // current bit count as an index.
                                    len_re  = 1'b1;
                                    len_ra  = r_bits[acc_t][LEN_AW-1:0];
                                    n_len   = acc_len[BITS_W-1:0];
                                    n_pc    = PC_W'({r_partial[acc_t], i_in.bit_req});
                                    n_state = S_LOOK;
                                end
                            end
                            default: begin
                                done = 1'b1;
                            end
                        endcase
                    end
                end
            end
            S_FIN: begin
                len_we_fo  = 1'b1;
                len_wt     = r_tbl;
                len_wa     = r_fin_idx;
                n_total    = fin_tot;
                n_oversub  = fin_ovs;
                n_code     = r_oversub ? r_code : (fin_sum << 1);
                n_fin_long = (rd_cnt != '0) ? fin_len : r_fin_long;
                if (r_fin_idx == LAST_LEN_IX) begin
                    done = 1'b1;
                    if (fin_tot > TOT_W'(MAX_SYMBOLS)) begin
                        done_status = ST_TOO_MANY;
                    end else if (fin_ovs) begin
                        done_status = ST_UNUSABLE;
                    end else begin
                        ev_fin_ok = 1'b1;
                    end
                end else begin
                    len_re    = 1'b1;
                    len_rt    = r_tbl;
                    len_ra    = r_fin_idx + LEN_AW'(1);
                    n_fin_idx = r_fin_idx + LEN_AW'(1);
                end
            end
            S_LOOK: begin
                ev_walk = 1'b1;
                if (lk_match) begin
                    walk_pc   = '0;
                    walk_bits = '0;
                    if (lk_idx < IDX_W'(MAX_SYMBOLS)) begin
                        sym_re  = 1'b1;
                        n_state = S_SYM;
                    end else begin
                        done        = 1'b1;
                        done_status = ST_SYMBOL;
                        done_clen   = CLEN_W'(r_len);
                    end
                end else begin
                    walk_pc   = r_pc;
                    walk_bits = r_len;
                    done      = 1'b1;
                end
            end
            S_SYM: begin
                done        = 1'b1;
                done_status = ST_SYMBOL;
                done_sym    = r_sym_rd;
                done_clen   = CLEN_W'(r_len);
            end
            S_PUSH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (done) begin
            if (out_free) begin
                n_state = S_IDLE;
            end else begin
                n_res_status = done_status;
                n_res_sym    = done_sym;
                n_res_clen   = done_clen;
                n_state      = S_PUSH;
            end
        end
    end

    // Count memory: counts are written by request beats, first codes and
    // offsets by the finish sweep.
    always_ff @(posedge i_clk) begin
        if (len_we_cnt) begin
            r_len_mem[len_wt][len_wa].cnt <= i_in.byte_value;
        end
        if (len_we_fo) begin
            r_len_mem[len_wt][len_wa].first <= FIRST_W'(r_code);
            r_len_mem[len_wt][len_wa].off   <= OFF_W'(r_total);
        end
        if (len_re) begin
            r_len_rd <= r_len_mem[len_rt][len_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (sym_we) begin
            r_sym_mem[acc_t][i_in.position[SYM_AW-1:0]] <= i_in.byte_value;
        end
        if (sym_re) begin
            r_sym_rd <= r_sym_mem[r_tbl][sym_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_cnt_vld <= '0;
            r_usable  <= '0;
            r_stuck   <= '0;
            for (int i = 0; i < TABLE_COUNT; i++) begin
                r_longest[i] <= '0;
                r_partial[i] <= '0;
                r_bits[i]    <= '0;
            end
        end else begin
            if (len_re) begin
                r_rd_vld <= r_cnt_vld[len_rt][len_ra];
            end
            if (len_we_cnt) begin
                r_cnt_vld[acc_t][len_wa] <= 1'b1;
            end
            if (ev_begin) begin
                r_cnt_vld[acc_t] <= '0;
            end
            if (ev_begin || ev_fin_start) begin
                r_usable[acc_t]  <= 1'b0;
                r_stuck[acc_t]   <= 1'b0;
                r_partial[acc_t] <= '0;
                r_bits[acc_t]    <= '0;
            end
            if (ev_stuck) begin
                r_stuck[acc_t] <= 1'b1;
            end
            if (ev_walk) begin
                r_partial[r_tbl] <= walk_pc;
                r_bits[r_tbl]    <= walk_bits;
            end
            if (ev_fin_ok) begin
                r_usable[r_tbl]  <= 1'b1;
                r_longest[r_tbl] <= n_fin_long;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (done && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_state == S_PUSH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tbl        <= n_tbl;
        r_len        <= n_len;
        r_pc         <= n_pc;
        r_fin_idx    <= n_fin_idx;
        r_code       <= n_code;
        r_total      <= n_total;
        r_fin_long   <= n_fin_long;
        r_oversub    <= n_oversub;
        r_res_status <= n_res_status;
        r_res_sym    <= n_res_sym;
        r_res_clen   <= n_res_clen;
        if (done && out_free) begin
            r_out_status <= done_status;
            r_out_sym    <= done_sym;
            r_out_clen   <= done_clen;
        end else if (r_state == S_PUSH && out_free) begin
            r_out_status <= r_res_status;
            r_out_sym    <= r_res_sym;
            r_out_clen   <= r_res_clen;
        end
    end

endmodule

[sv/jhd_checker.sv]
// ============================================================================
// JPEG Huffman bit decoder checker
// Port-level properties of the result channel, bound to the decoder.
// ============================================================================
module jhd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [jhd_pkg::STATUS_W-1:0]  i_out_status,
    input logic [jhd_pkg::BYTE_W-1:0]    i_out_symbol,
    input logic [jhd_pkg::CLEN_W-1:0]    i_out_code_length
);
    import jhd_pkg::*;

    // Reset empties the result register.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // A stalled result beat keeps its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_status) && $stable(i_out_symbol)
            && $stable(i_out_code_length))
        else $error("stalled result beat changed");

    // A decoded symbol always reports a code length within the code space.
    a_sym_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status == ST_SYMBOL |->
            i_out_code_length != '0 && i_out_code_length <= CLEN_W'(16))
        else $error("symbol without a valid code length");

    // Any other result carries no symbol and no code length.
    a_no_sym: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status != ST_SYMBOL |->
            i_out_symbol == '0 && i_out_code_length == '0)
        else $error("symbol fields set on a non-symbol result");

endmodule

bind jpeg_huffman_bit_decoder jhd_checker u_jhd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_status      (o_out.status),
    .i_out_symbol      (o_out.symbol),
    .i_out_code_length (o_out.code_length)
);

[dv/jhd_decode_score_pkg.sv]
// ============================================================================
// JPEG Huffman bit decoder scoreboard
// Keeps a copy of every table's counts, symbols, canonical code bounds and
// walk state. Each request beat gives one predicted result beat, and each
// result beat from the decoder is checked against the oldest prediction.
// ============================================================================
package jhd_decode_score_pkg;
    import jhd_pkg::*;

    localparam int CODE_LEN_MAX = 16;
    localparam int TABLES       = 8;
    localparam int SYMBOLS_MAX  = 256;

    // Kinds that the decoder answers without acting on them.
    localparam logic [KIND_W-1:0] K_SPARE_LO = 3'd5;
    localparam logic [KIND_W-1:0] K_SPARE_HI = 3'd7;

    typedef struct {
        logic [KIND_W-1:0]    kind;
        logic [TBL_REQ_W-1:0] table_req;
        logic [POS_W-1:0]     position;
        logic [BYTE_W-1:0]    byte_value;
        logic                 bit_req;
    } request_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   symbol;
        logic [CLEN_W-1:0]   code_length;
    } result_t;

    class huffman_scoreboard;
        bit [BYTE_W-1:0] counts [TABLES][CODE_LEN_MAX+1];
        bit [BYTE_W-1:0] symbols [TABLES][SYMBOLS_MAX];
        bit              written [TABLES][SYMBOLS_MAX];
        int              first_code [TABLES][CODE_LEN_MAX+1];
        int              sym_offset [TABLES][CODE_LEN_MAX+1];
        int              longest [TABLES];
        bit [15:0]       partial [TABLES];
        int              bits_read [TABLES];
        bit              usable [TABLES];
        bit              stuck [TABLES];
        result_t         expected_results [$];
        int              errors;

        function void clear_walk(int t);
            partial[t]   = '0;
            bits_read[t] = 0;
            stuck[t]     = 1'b0;
        endfunction

        // Assigns canonical codes; bounds already written stay even when a
        // later length oversubscribes the tree.
        function logic [STATUS_W-1:0] finish_table(int t);
            int total;
            int code;
            int deepest;
            int len;
            clear_walk(t);
            usable[t] = 1'b0;
            total = 0;
            for (len = 1; len <= CODE_LEN_MAX; len++) total += counts[t][len];
            if (total > SYMBOLS_MAX) return ST_TOO_MANY;
            total   = 0;
            code    = 0;
            deepest = 0;
            for (len = 1; len <= CODE_LEN_MAX; len++) begin
                first_code[t][len] = code;
                sym_offset[t][len] = total;
                code  += counts[t][len];
                total += counts[t][len];
                if (code > (1 << len)) return ST_UNUSABLE;
                if (counts[t][len] != 0) deepest = len;
                code = code << 1;
            end
            longest[t] = deepest;
            usable[t]  = 1'b1;
            return ST_OK;
        endfunction

        // One bit of the walk. With commit low the state is left alone, so the
        // stimulus can look ahead at the symbol slot a bit would read.
        function result_t decode_bit(int t, bit b, bit commit, output int slot);
            result_t r;
            int      len;
            int      pc;
            int      first;
            int      n;
            int      idx;
            r    = '{ST_OK, 8'd0, 5'd0};
            slot = -1;
            if (!usable[t]) begin
                r.status = ST_UNUSABLE;
            end else if (stuck[t]) begin
                r.status = ST_STUCK;
            end else begin
                len = bits_read[t] + 1;
                if (len > longest[t] || len > CODE_LEN_MAX) begin
                    if (commit) stuck[t] = 1'b1;
                    r.status = ST_STUCK;
                end else begin
                    pc    = {partial[t][14:0], b};
                    n     = counts[t][len];
                    first = first_code[t][len];
                    if (n != 0 && pc >= first && pc - first < n) begin
                        idx = sym_offset[t][len] + pc - first;
                        if (idx < SYMBOLS_MAX) begin
                            slot     = idx;
                            r.symbol = symbols[t][idx];
                        end
                        r.code_length = CLEN_W'(len);
                        r.status      = ST_SYMBOL;
                        if (commit) begin
                            partial[t]   = '0;
                            bits_read[t] = 0;
                        end
                    end else if (commit) begin
                        partial[t]   = pc[15:0];
                        bits_read[t] = len;
                    end
                end
            end
            return r;
        endfunction

        function bit slot_unwritten(int t, bit b, output int slot);
            void'(decode_bit(t, b, 1'b0, slot));
            return slot >= 0 && !written[t][slot];
        endfunction

        function void note_request(request_t q);
            result_t r;
            int      t;
            int      slot;
            int      len;
            r = '{ST_OK, 8'd0, 5'd0};
            t = q.table_req;
            if (t >= TABLES) begin
                r.status = ST_UNUSABLE;
            end else begin
                case (q.kind)
                    K_BEGIN: begin
                        for (len = 0; len <= CODE_LEN_MAX; len++) counts[t][len] = '0;
                        usable[t] = 1'b0;
                        clear_walk(t);
                    end
                    K_COUNT: begin
                        if (q.position < CODE_LEN_MAX) counts[t][q.position + 1] = q.byte_value;
                    end
                    K_SYMBOL: begin
                        if (q.position < SYMBOLS_MAX) begin
                            symbols[t][q.position] = q.byte_value;
                            written[t][q.position] = 1'b1;
                        end
                    end
                    K_FINISH: r.status = finish_table(t);
                    K_DECODE: r = decode_bit(t, q.bit_req, 1'b1, slot);
                    default: ;
                endcase
            end
            expected_results.push_back(r);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        task report_mismatch(string what, int got_v, int want_v);
            errors++;
            $display("%0t ns: %s: got %0d, want %0d", $time, what, got_v, want_v);
        endtask

        task check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0) begin
                report_mismatch("result beat with no request waiting", got.status, -1);
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.symbol !== want.symbol)
                    report_mismatch("symbol", got.symbol, want.symbol);
                if (got.code_length !== want.code_length)
                    report_mismatch("code_length", got.code_length, want.code_length);
            end
        endtask
    endclass

endpackage

[dv/jpeg_huffman_bit_decoder_test.sv]
// ============================================================================
// JPEG Huffman bit decoder test
// Loads canonical tables (good, oversubscribed, oversized and empty ones),
// decodes well-formed code streams mixed with stray bits and noise beats,
// and checks every result beat against the scoreboard's prediction while
// both channels idle and stall at random.
// ============================================================================
module jpeg_huffman_bit_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import jhd_pkg::*;
    import jhd_decode_score_pkg::*;

    localparam int TARGET_BEATS = 700;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 40;
    localparam int CYCLE_LIMIT  = 500000;

    logic i_clk;
    logic i_rst_n;

    jhd_in_if  in_ch ();
    jhd_out_if out_ch ();

    jpeg_huffman_bit_decoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    huffman_scoreboard sb = new;

    int hold_asks;
    int burst_left;
    int counted_beats;
    int cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("jpeg_huffman_bit_decoder_test: done, errors");
        $finish;
    end

    // Result side: runs of always-ready, a rotating stall pattern, or random
    // stalls, plus a long hold-off whenever the stimulus asks for one.
    initial begin : result_sink
        int        hold_seen;
        int        hold_left;
        int        mode;
        int        mode_left;
        bit [31:0] pattern;
        hold_seen = 0;
        hold_left = 0;
        mode      = 0;
        mode_left = 0;
        pattern   = '1;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(16, 160);
                    pattern   = $urandom | 32'h1;
                end
                mode_left--;
                case (mode)
                    0: out_ch.ready <= 1'b1;
                    1: begin
                        out_ch.ready <= pattern[0];
                        pattern = {pattern[0], pattern[31:1]};
                    end
                    default: out_ch.ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : result_watch
        result_t got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.status      = out_ch.status;
            got.symbol      = out_ch.symbol;
            got.code_length = out_ch.code_length;
            sb.check_result(got);
        end
    end

    function automatic int min_of(int a, int b);
        return (a < b) ? a : b;
    endfunction

    // Offers one request beat, with a random gap whenever a burst runs out,
    // and returns at the edge where the beat is taken.
    task automatic send_beat(int kind, int t, int pos, int val, int b);
        request_t q;
        int       gap;
        q.kind       = KIND_W'(kind);
        q.table_req  = TBL_REQ_W'(t);
        q.position   = POS_W'(pos);
        q.byte_value = BYTE_W'(val);
        q.bit_req    = 1'(b);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= q.kind;
        in_ch.table_req  <= q.table_req;
        in_ch.position   <= q.position;
        in_ch.byte_value <= q.byte_value;
        in_ch.bit_req    <= q.bit_req;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_request(q);
        if (!(q.kind >= K_SPARE_LO ||
              (q.kind == K_COUNT && q.position >= POS_W'(CODE_LEN_MAX))))
            counted_beats++;
    endtask

    // A bit that would land on a symbol slot never loaded gets that slot
    // written first, so every decoded symbol has a defined value.
    task automatic send_decode(int t, bit b);
        int slot;
        if (sb.slot_unwritten(t, b, slot))
            send_beat(K_SYMBOL, t, slot, $urandom, $urandom);
        send_beat(K_DECODE, t, $urandom, $urandom, b);
    endtask

    task automatic send_codeword(int t);
        int lens [$];
        int len;
        int code;
        int i;
        for (len = 1; len <= sb.longest[t]; len++)
            if (sb.counts[t][len] != 0) lens.push_back(len);
        if (lens.size() == 0) begin
            send_decode(t, 1'($urandom_range(0, 1)));
        end else begin
            len  = lens[$urandom_range(0, lens.size() - 1)];
            code = sb.first_code[t][len] + $urandom_range(0, sb.counts[t][len] - 1);
            for (i = len - 1; i >= 0; i--) send_decode(t, code[i]);
        end
    endtask

    // shape: 0 well-formed, 1 oversubscribed tree, 2 more symbols than allowed.
    task automatic load_table(int t, int shape);
        int n [CODE_LEN_MAX+1];
        int len;
        int roll;
        int maxlen;
        int budget;
        int code;
        int avail;
        int lim;
        int total;
        int start;
        int i;
        int p;
        send_beat(K_BEGIN, t, $urandom, $urandom, $urandom);
        for (len = 0; len <= CODE_LEN_MAX; len++) n[len] = 0;
        roll   = $urandom_range(0, 9);
        maxlen = (roll < 7) ? $urandom_range(1, 6) :
                 (roll < 9) ? $urandom_range(7, 12) : $urandom_range(13, CODE_LEN_MAX);
        budget = ($urandom_range(0, 9) == 0) ? $urandom_range(21, SYMBOLS_MAX)
                                             : $urandom_range(1, 20);
        code = 0;
        for (len = 1; len <= maxlen; len++) begin
            avail = (1 << len) - code;
            lim   = min_of(min_of(avail, budget), COUNT_MAX);
            if (len < maxlen) begin
                // Keep a free prefix so that deeper lengths still get codes.
                lim    = min_of(lim, avail - 1);
                n[len] = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, lim);
            end else if (lim > 0) begin
                // Taking every free prefix puts the all-ones code in use.
                n[len] = ($urandom_range(0, 2) == 0) ? lim : $urandom_range(1, lim);
            end
            code    = (code + n[len]) << 1;
            budget -= n[len];
        end
        if (shape == 1) begin
            len    = $urandom_range(1, 7);
            n[len] = min_of(COUNT_MAX, n[len] + (1 << len) + 1);
        end else if (shape == 2) begin
            n[CODE_LEN_MAX] = COUNT_MAX;
            n[$urandom_range(1, CODE_LEN_MAX - 1)] = $urandom_range(2, COUNT_MAX);
        end
        start = $urandom_range(0, CODE_LEN_MAX - 1);
        for (i = 0; i < CODE_LEN_MAX; i++) begin
            p = (start + i) % CODE_LEN_MAX;
            if (n[p + 1] != 0 || $urandom_range(0, 3) == 0)
                send_beat(K_COUNT, t, p, n[p + 1], $urandom);
        end
        if ($urandom_range(0, 7) == 0)
            send_beat(K_COUNT, t, $urandom_range(CODE_LEN_MAX, 255), $urandom, $urandom);
        total = 0;
        for (len = 1; len <= CODE_LEN_MAX; len++) total += n[len];
        for (i = 0; i < min_of(total, 32); i++)
            send_beat(K_SYMBOL, t, i, $urandom, $urandom);
        send_beat(K_FINISH, t, $urandom, $urandom, $urandom);
    endtask

    task automatic wait_all_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int live [$];
        int pick;
        int t;
        int k;
        int roll;
        bit second_hold;
        hold_asks     <= 0;
        burst_left    = 0;
        counted_beats = 0;
        second_hold   = 1'b0;
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.kind       <= K_BEGIN;
        in_ch.table_req  <= '0;
        in_ch.position   <= '0;
        in_ch.byte_value <= '0;
        in_ch.bit_req    <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Decode before any load, and the spare kinds.
        send_decode(0, 1'b1);
        send_beat(K_SPARE_LO, 0, 8'h00, 8'h00, 1'b0);
        send_beat(K_SPARE_HI, 7, 8'hFF, 8'hFF, 1'b1);
        // A finished empty table goes stuck on its first bit and stays stuck.
        send_beat(K_FINISH, 1, 8'h00, 8'h00, 1'b0);
        send_decode(1, 1'b0);
        send_decode(1, 1'b1);
        // Two one-bit codes fill the tree, the all-ones code among them.
        send_beat(K_BEGIN, 2, 8'hFF, 8'hFF, 1'b1);
        send_beat(K_COUNT, 2, 8'd0, 8'd2, 1'b0);
        send_beat(K_COUNT, 2, 8'd200, 8'hFF, 1'b0);
        send_beat(K_SYMBOL, 2, 8'd0, 8'h00, 1'b0);
        send_beat(K_SYMBOL, 2, 8'd1, 8'hFF, 1'b1);
        send_beat(K_SYMBOL, 2, 8'hFF, 8'hA5, 1'b0);
        send_beat(K_FINISH, 2, 8'h00, 8'h00, 1'b0);
        send_decode(2, 1'b0);
        send_decode(2, 1'b1);
        // Three one-bit codes oversubscribe the tree.
        send_beat(K_COUNT, 3, 8'd0, 8'd3, 1'b0);
        send_beat(K_FINISH, 3, 8'h00, 8'h00, 1'b0);
        send_decode(3, 1'b0);
        // More symbols than a table may hold.
        send_beat(K_COUNT, 4, 8'd15, 8'hFF, 1'b0);
        send_beat(K_COUNT, 4, 8'd14, 8'hFF, 1'b0);
        send_beat(K_FINISH, 4, 8'h00, 8'h00, 1'b0);
        // One two-bit code; a third bit runs past the longest length.
        send_beat(K_COUNT, 5, 8'd1, 8'd1, 1'b0);
        send_beat(K_SYMBOL, 5, 8'd0, 8'h3C, 1'b1);
        send_beat(K_FINISH, 5, 8'h00, 8'h00, 1'b0);
        send_decode(5, 1'b1);
        send_decode(5, 1'b1);
        send_decode(5, 1'b1);
        wait_all_results();

        // The receiver holds off while beats keep coming, filling the decoder.
        hold_asks <= hold_asks + 1;
        while (counted_beats < TARGET_BEATS) begin
            if (!second_hold && counted_beats > TARGET_BEATS / 2) begin
                second_hold = 1'b1;
                wait_all_results();
                hold_asks <= hold_asks + 1;
            end
            live.delete();
            for (t = 0; t < TABLES; t++) if (sb.usable[t]) live.push_back(t);
            pick = $urandom_range(0, 99);
            if (pick < 45 && live.size() != 0) begin
                t = live[$urandom_range(0, live.size() - 1)];
                k = $urandom_range(1, 6);
                repeat (k) send_codeword(t);
                if ($urandom_range(0, 4) == 0) send_decode(t, 1'($urandom_range(0, 1)));
            end else if (pick < 72) begin
                roll = $urandom_range(0, 9);
                load_table($urandom_range(0, TABLES - 1), (roll < 2) ? roll + 1 : 0);
            end else if (pick < 84) begin
                t = $urandom_range(0, TABLES - 1);
                repeat ($urandom_range(1, 20)) send_decode(t, 1'($urandom_range(0, 1)));
            end else if (pick < 97) begin
                k = $urandom_range(0, 7);
                if (k == K_DECODE)
                    send_decode($urandom_range(0, TABLES - 1), 1'($urandom_range(0, 1)));
                else
                    send_beat(k, $urandom, $urandom, $urandom, $urandom);
            end else begin
                wait_all_results();
            end
        end

        wait_all_results();
        repeat (SETTLE) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("jpeg_huffman_bit_decoder_test: done, clean");
        else
            $display("jpeg_huffman_bit_decoder_test: done, errors");
        $finish;
    end

endmodule

[filelist.f]
sv/jhd_pkg.sv
sv/jhd_ifs.sv
sv/jpeg_huffman_bit_decoder.sv
sv/jhd_checker.sv
dv/jhd_decode_score_pkg.sv
dv/jpeg_huffman_bit_decoder_test.sv
